// ===== hdl/bptc_pkg.sv =====
// ----------------------------------------------------------------------------
// bptc_pkg
// shared constants and helpers for the barometric compensation block
// ----------------------------------------------------------------------------
package bptc_pkg;

   localparam int unsigned DataW = 32;
   localparam int unsigned RawW  = 24;
   localparam int unsigned CsrW  = 48;
   localparam int unsigned CsrIW = 3;

   // register indexes
   localparam logic [CsrIW-1:0] CSR_OSS    = 3'd0;
   localparam logic [CsrIW-1:0] CSR_AC_S   = 3'd1;
   localparam logic [CsrIW-1:0] CSR_AC_U   = 3'd2;
   localparam logic [CsrIW-1:0] CSR_B_PAIR = 3'd3;
   localparam logic [CsrIW-1:0] CSR_M_PAIR = 3'd4;

   // item kinds
   localparam logic KIND_TEMP  = 1'b0;
   localparam logic KIND_PRESS = 1'b1;

   typedef logic signed [DataW-1:0] word_type;

   // signed divide by 2**k, truncating toward zero
   function automatic word_type sdiv_p2(input word_type v, input logic [4:0] k);
      logic [DataW-1:0] bias;
      bias = v[DataW-1] ? ((32'd1 << k) - 32'd1) : 32'd0;
      return word_type'(v + word_type'(bias)) >>> k;
   endfunction

   function automatic word_type sext16(input logic [15:0] x);
      return word_type'({{16{x[15]}}, x});
   endfunction

   function automatic word_type zext16(input logic [15:0] x);
      return word_type'({16'd0, x});
   endfunction

endpackage

// ===== hdl/baro_temp_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// integer temperature and pressure compensation for a barometric sensor
// ----------------------------------------------------------------------------
// Input beats carry a raw sample on req_tdata and the item kind on
// req_tuser (0 temperature, 1 pressure). Each input beat gives exactly one
// output beat: result value on rsp_tdata, kind and divide fault on rsp_tuser.
// The user must write calibration words and the oversampling mode through
// the csr_ port while the block is idle; the block itself does not enforce
// it. They take effect on the next item. One item is worked at a time by a
// sequencer around one shared multiplier and one bit-serial divider; a new
// item is taken only once the last one has left the sequencer. A zero
// divisor skips the divide and finishes early.
// req_tready is high only while the sequencer is idle. A finished result
// sits in the output register until taken; if the receiver stalls, the next
// item still runs and waits in its last step until the output frees up.
// Reset (synchronous) clears the calibration registers, the stored B5 term
// and all handshake state.
module baro_temp_pressure_compensation (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [23:0]                req_tdata,  // raw_reading
   input  logic                       req_tuser,  // cmd
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata,  // result_value
   output logic [1:0]                 rsp_tuser,  // result_kind, divide_fault
   input  logic                       csr_we,
   input  logic [bptc_pkg::CsrIW-1:0] csr_index,
   input  logic [bptc_pkg::CsrW-1:0]  csr_wdata
);
   import bptc_pkg::*;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_OUT  = 5'd1;
   localparam logic [4:0] S_T0   = 5'd2;
   localparam logic [4:0] S_T1   = 5'd3;
   localparam logic [4:0] S_T2   = 5'd4;
   localparam logic [4:0] S_TD   = 5'd5;
   localparam logic [4:0] S_T3   = 5'd6;
   localparam logic [4:0] S_T4   = 5'd7;
   localparam logic [4:0] S_P0   = 5'd8;
   localparam logic [4:0] S_P1   = 5'd9;
   localparam logic [4:0] S_P2   = 5'd10;
   localparam logic [4:0] S_P3   = 5'd11;
   localparam logic [4:0] S_P4   = 5'd12;
   localparam logic [4:0] S_P5   = 5'd13;
   localparam logic [4:0] S_P6   = 5'd14;
   localparam logic [4:0] S_P7   = 5'd15;
   localparam logic [4:0] S_P8   = 5'd16;
   localparam logic [4:0] S_P9   = 5'd17;
   localparam logic [4:0] S_P10  = 5'd18;
   localparam logic [4:0] S_P11  = 5'd19;
   localparam logic [4:0] S_PD   = 5'd20;
   localparam logic [4:0] S_P12  = 5'd21;
   localparam logic [4:0] S_P13  = 5'd22;
   localparam logic [4:0] S_P14  = 5'd23;
   localparam logic [4:0] S_P15  = 5'd24;
   localparam logic [4:0] S_P16  = 5'd25;
   localparam logic [4:0] S_P17  = 5'd26;

   // configuration
   logic [1:0]  oss_ff;
   logic [47:0] acs_ff, acu_ff;
   logic [31:0] bp_ff, mp_ff;

   logic [4:0]  state_ff, state_in;
   logic [23:0] raw_ff, raw_in;
   word_type    b5_ff, b5_in;
   word_type    xa_ff, xa_in, xb_ff, xb_in;
   word_type    b6_ff, b6_in, t_ff, t_in;
   word_type    b3_ff, b3_in, p_ff, p_in;
   logic [31:0] b4_ff, b4_in;
   logic        neg_ff, neg_in, dbl_ff, dbl_in;
   word_type    res_ff, res_in;
   logic        resk_ff, resk_in, resf_ff, resf_in;
   logic        ov_ff, ov_in;
   word_type    od_ff, od_in;
   logic        ok_ff, ok_in, of_ff, of_in;

   logic [31:0] mul_a, mul_b, prod;
   logic        div_start, div_done;
   logic [31:0] div_num, div_den, div_quo;

   word_type ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   word_type d, num_s, up, q_s;
   logic [31:0] b7;

   assign ac1 = sext16(acs_ff[47:32]);
   assign ac2 = sext16(acs_ff[31:16]);
   assign ac3 = sext16(acs_ff[15:0]);
   assign ac4 = zext16(acu_ff[47:32]);
   assign ac5 = zext16(acu_ff[31:16]);
   assign ac6 = zext16(acu_ff[15:0]);
   assign b1  = sext16(bp_ff[31:16]);
   assign b2  = sext16(bp_ff[15:0]);
   assign mc  = sext16(mp_ff[31:16]);
   assign md  = sext16(mp_ff[15:0]);

   bptc_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   bptc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .done  (div_done)
   );

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      raw_in    = raw_ff;
      b5_in     = b5_ff;
      xa_in     = xa_ff;
      xb_in     = xb_ff;
      b6_in     = b6_ff;
      t_in      = t_ff;
      b3_in     = b3_ff;
      b4_in     = b4_ff;
      p_in      = p_ff;
      neg_in    = neg_ff;
      dbl_in    = dbl_ff;
      res_in    = res_ff;
      resk_in   = resk_ff;
      resf_in   = resf_ff;
      ov_in     = ov_ff;
      od_in     = od_ff;
      ok_in     = ok_ff;
      of_in     = of_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      d         = xa_ff + md;
      num_s     = mc <<< 11;
      up        = word_type'({8'd0, raw_ff >> (4'd8 - {2'd0, oss_ff})});
      b7        = prod;
      q_s       = neg_ff ? -word_type'(div_quo) : word_type'(div_quo);

      if (ov_ff && rsp_tready) begin
         ov_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               raw_in   = req_tdata;
               resk_in  = req_tuser;
               resf_in  = 1'b0;
               state_in = (req_tuser == KIND_PRESS) ? S_P0 : S_T0;
            end
         end
         S_OUT: begin
            if (!ov_ff || rsp_tready) begin
               ov_in    = 1'b1;
               od_in    = res_ff;
               ok_in    = resk_ff;
               of_in    = resf_ff;
               state_in = S_IDLE;
            end
         end
         // temperature
         S_T0: begin
            mul_a    = zext16(raw_ff[15:0]) - ac6;
            mul_b    = ac5;
            state_in = S_T1;
         end
         S_T1: begin
            xa_in    = sdiv_p2(prod, 5'd15);
            state_in = S_T2;
         end
         S_T2: begin
            if (d == '0) begin
               resf_in  = 1'b1;
               res_in   = '0;
               state_in = S_OUT;
            end else begin
               div_start = 1'b1;
               div_num   = num_s[31] ? -num_s : num_s;
               div_den   = d[31] ? -d : d;
               neg_in    = num_s[31] ^ d[31];
               state_in  = S_TD;
            end
         end
         S_TD: begin
            if (div_done) begin
               xb_in    = q_s;
               state_in = S_T3;
            end
         end
         S_T3: begin
            b5_in    = xa_ff + xb_ff;
            state_in = S_T4;
         end
         S_T4: begin
            res_in   = sdiv_p2(b5_ff + 32'sd8, 5'd4);
            state_in = S_OUT;
         end
         // pressure
         S_P0: begin
            b6_in    = b5_ff - 32'sd4000;
            state_in = S_P1;
         end
         S_P1: begin
            mul_a    = b6_ff;
            mul_b    = b6_ff;
            state_in = S_P2;
         end
         S_P2: begin
            t_in     = sdiv_p2(prod, 5'd12);
            state_in = S_P3;
         end
         S_P3: begin
            mul_a    = b2;
            mul_b    = t_ff;
            state_in = S_P4;
         end
         S_P4: begin
            xa_in    = sdiv_p2(prod, 5'd11);
            mul_a    = ac2;
            mul_b    = b6_ff;
            state_in = S_P5;
         end
         S_P5: begin
            xa_in    = xa_ff + sdiv_p2(prod, 5'd11);
            mul_a    = ac3;
            mul_b    = b6_ff;
            state_in = S_P6;
         end
         S_P6: begin
            xb_in    = sdiv_p2(prod, 5'd13);
            mul_a    = b1;
            mul_b    = t_ff;
            state_in = S_P7;
         end
         S_P7: begin
            xb_in    = xb_ff + sdiv_p2(prod, 5'd16);
            b3_in    = ((ac1 <<< 2) + xa_ff) <<< oss_ff;
            state_in = S_P8;
         end
         S_P8: begin
            b3_in    = sdiv_p2(b3_ff + 32'sd2, 5'd2);
            xb_in    = sdiv_p2(xb_ff + 32'sd2, 5'd2);
            state_in = S_P9;
         end
         S_P9: begin
            mul_a    = ac4;
            mul_b    = xb_ff + 32'sd32768;
            state_in = S_P10;
         end
         S_P10: begin
            b4_in    = prod >> 15;
            mul_a    = up - b3_ff;
            mul_b    = 32'd50000 >> oss_ff;
            state_in = S_P11;
         end
         S_P11: begin
            if (b4_ff == '0) begin
               resf_in  = 1'b1;
               res_in   = '0;
               state_in = S_OUT;
            end else begin
               div_start = 1'b1;
               div_num   = b7[31] ? b7 : {b7[30:0], 1'b0};
               div_den   = b4_ff;
               dbl_in    = b7[31];
               state_in  = S_PD;
            end
         end
         S_PD: begin
            if (div_done) begin
               p_in     = dbl_ff ? word_type'({div_quo[30:0], 1'b0}) : word_type'(div_quo);
               state_in = S_P12;
            end
         end
         S_P12: begin
            mul_a    = sdiv_p2(p_ff, 5'd8);
            mul_b    = sdiv_p2(p_ff, 5'd8);
            state_in = S_P13;
         end
         S_P13: begin
            mul_a    = prod;
            mul_b    = 32'd3038;
            state_in = S_P14;
         end
         S_P14: begin
            xa_in    = sdiv_p2(prod, 5'd16);
            mul_a    = -32'sd7357;
            mul_b    = p_ff;
            state_in = S_P15;
         end
         S_P15: begin
            xb_in    = sdiv_p2(prod, 5'd16);
            state_in = S_P16;
         end
         S_P16: begin
            xa_in    = xa_ff + xb_ff + 32'sd3791;
            state_in = S_P17;
         end
         S_P17: begin
            res_in   = p_ff + sdiv_p2(xa_ff, 5'd4);
            state_in = S_OUT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff    <= 1'b0;
         b5_ff    <= '0;
         oss_ff   <= '0;
         acs_ff   <= '0;
         acu_ff   <= '0;
         bp_ff    <= '0;
         mp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         b5_ff    <= b5_in;
         if (csr_we) begin
            case (csr_index)
               CSR_OSS:    oss_ff <= csr_wdata[1:0];
               CSR_AC_S:   acs_ff <= csr_wdata;
               CSR_AC_U:   acu_ff <= csr_wdata;
               CSR_B_PAIR: bp_ff  <= csr_wdata[31:0];
               CSR_M_PAIR: mp_ff  <= csr_wdata[31:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      raw_ff  <= raw_in;
      xa_ff   <= xa_in;
      xb_ff   <= xb_in;
      b6_ff   <= b6_in;
      t_ff    <= t_in;
      b3_ff   <= b3_in;
      b4_ff   <= b4_in;
      p_ff    <= p_in;
      neg_ff  <= neg_in;
      dbl_ff  <= dbl_in;
      res_ff  <= res_in;
      resk_ff <= resk_in;
      resf_ff <= resf_in;
      od_ff   <= od_in;
      ok_ff   <= ok_in;
      of_ff   <= of_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = {of_ff, ok_ff};

`ifndef ASSERT_OFF
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is in work");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_TD || state_ff == S_PD))
      else $error("divider finished outside a wait step");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == '0)
      else $error("fault beat with non-zero value");
`endif
endmodule

// ===== hdl/bptc_mul.sv =====
// ----------------------------------------------------------------------------
// bptc_mul
// shared 32 x 32 multiplier, low word of the product, registered
// ----------------------------------------------------------------------------
module bptc_mul (
   input  logic                     clock,
   input  logic [bptc_pkg::DataW-1:0] op_a,
   input  logic [bptc_pkg::DataW-1:0] op_b,
   output logic [bptc_pkg::DataW-1:0] prod_ff
);
   import bptc_pkg::*;

   logic [2*DataW-1:0] full;

   // the low word is the same for signed and unsigned operands
   assign full = {{DataW{1'b0}}, op_a} * {{DataW{1'b0}}, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= full[DataW-1:0];
   end
endmodule

// ===== hdl/bptc_div.sv =====
// ----------------------------------------------------------------------------
// bptc_div
// unsigned 32 / 32 restoring divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module bptc_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [bptc_pkg::DataW-1:0] num,
   input  logic [bptc_pkg::DataW-1:0] den,
   output logic [bptc_pkg::DataW-1:0] quo,
   output logic                     done
);
   import bptc_pkg::*;

   logic [DataW:0]   rem_ff, rem_in;
   logic [DataW-1:0] quo_ff, quo_in;
   logic [DataW-1:0] den_ff, den_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DataW:0]   trial;
   logic [DataW:0]   diff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DataW-1:0], quo_ff[DataW-1]};
      diff    = trial - {1'b0, den_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DataW]) begin
            rem_in = diff;
            quo_in = {quo_ff[DataW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DataW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quo  = quo_ff;
   assign done = done_ff;
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the barometric compensation block: random and
// directed raw samples under several calibration sets, results predicted in
// the bench and compared beat by beat
// ----------------------------------------------------------------------------
module tb;
   import bptc_pkg::*;

   typedef struct packed {
      logic        kind;
      logic [23:0] raw;
   } sample_t;

   typedef struct packed {
      logic        kind;
      logic [31:0] value;
      logic        fault;
   } reading_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [23:0]         req_tdata = '0;
   logic                req_tuser = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [31:0]         rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                csr_we = 1'b0;
   logic [CsrIW-1:0]    csr_index = '0;
   logic [CsrW-1:0]     csr_wdata = '0;

   // bench copy of the block's registers and stored term
   logic [1:0]          oss_q;
   logic [47:0]         ac_s_q, ac_u_q;
   logic [31:0]         b_pair_q, m_pair_q;
   logic signed [31:0]  b5_q;

   sample_t             pending_samples[$];
   reading_t            expected_readings[$];
   int unsigned         send_idle_pct = 0, recv_idle_pct = 0;
   int unsigned         hold_left = 0;
   int unsigned         cycle_count = 0;
   bit                  failed = 1'b0;

   baro_temp_pressure_compensation u_top (.*);

   always #10 clock = ~clock;

   // signed divide truncating toward zero, wrapping on min / -1
   function automatic logic signed [31:0] sdiv(input logic signed [31:0] n,
                                               input logic signed [31:0] d);
      if (n == 32'sh8000_0000 && d == -32'sd1) return n;
      return n / d;
   endfunction

   function automatic logic signed [31:0] s16w(input logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

   function automatic reading_t compensate(input sample_t s);
      reading_t r;
      logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md, ac5, ac6, ut;
      logic signed [31:0] x1, x2, x3, dv, b5, b6, t, b3, p;
      logic [31:0] ac4, up, b4, b7, q;
      logic [63:0] wide;
      r.kind = s.kind;
      r.fault = 1'b0;
      r.value = '0;
      ac1 = s16w(ac_s_q[47:32]); ac2 = s16w(ac_s_q[31:16]); ac3 = s16w(ac_s_q[15:0]);
      ac4 = {16'd0, ac_u_q[47:32]};
      ac5 = {16'd0, ac_u_q[31:16]}; ac6 = {16'd0, ac_u_q[15:0]};
      b1 = s16w(b_pair_q[31:16]); b2 = s16w(b_pair_q[15:0]);
      mc = s16w(m_pair_q[31:16]); md = s16w(m_pair_q[15:0]);
      if (s.kind == KIND_TEMP) begin
         ut = {16'd0, s.raw[15:0]};
         x1 = sdiv((ut - ac6) * ac5, 32768);
         dv = x1 + md;
         if (dv == 0) begin
            r.fault = 1'b1;
         end else begin
            x2 = sdiv(mc * 2048, dv);
            b5 = x1 + x2;
            b5_q = b5;
            r.value = sdiv(b5 + 8, 16);
         end
      end else begin
         up = {8'd0, s.raw} >> (8 - oss_q);
         b6 = b5_q - 4000;
         t = sdiv(b6 * b6, 4096);
         x1 = sdiv(b2 * t, 2048);
         x2 = sdiv(ac2 * b6, 2048);
         x3 = x1 + x2;
         b3 = (ac1 * 4 + x3) << oss_q;
         b3 = sdiv(b3 + 2, 4);
         x1 = sdiv(ac3 * b6, 8192);
         x2 = sdiv(b1 * t, 65536);
         x3 = sdiv(x1 + x2 + 2, 4);
         wide = 64'(ac4) * 64'(32'(x3 + 32768));
         b4 = 32'(wide) / 32'd32768;
         b7 = (up - b3) * (32'd50000 >> oss_q);
         if (b4 == 0) begin
            r.fault = 1'b1;
         end else begin
            if (b7 < 32'h8000_0000) q = (b7 * 2) / b4;
            else q = (b7 / b4) * 2;
            p = q;
            x1 = sdiv(p, 256) * sdiv(p, 256);
            x1 = sdiv(x1 * 3038, 65536);
            x2 = sdiv(-32'sd7357 * p, 65536);
            x3 = sdiv(x1 + x2 + 3791, 16);
            r.value = p + x3;
         end
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            sample_t s;
            s = pending_samples.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= s.raw;
            req_tuser  <= s.kind;
            expected_readings.push_back(compensate(s));
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_readings.size() == 0) begin
            $error("unexpected result beat: value %0d", $signed(rsp_tdata));
            failed = 1'b1;
         end else begin
            reading_t e;
            e = expected_readings.pop_front();
            if (rsp_tuser[0] !== e.kind) begin
               $error("result_kind: expected %0d actual %0d", e.kind, rsp_tuser[0]);
               failed = 1'b1;
            end
            if (rsp_tdata !== e.value) begin
               $error("result_value: expected %0d actual %0d", $signed(e.value),
                      $signed(rsp_tdata));
               failed = 1'b1;
            end
            if (rsp_tuser[1] !== e.fault) begin
               $error("divide_fault: expected %0d actual %0d", e.fault, rsp_tuser[1]);
               failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 900000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_reg(input logic [CsrIW-1:0] idx, input logic [CsrW-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_OSS:    oss_q    = val[1:0];
         CSR_AC_S:   ac_s_q   = val[47:0];
         CSR_AC_U:   ac_u_q   = val[47:0];
         CSR_B_PAIR: b_pair_q = val[31:0];
         CSR_M_PAIR: m_pair_q = val[31:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // wait for the block to drain before touching registers
   task automatic drain();
      while (pending_samples.size() > 0 || expected_readings.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic load_cal(input int setting);
      logic [CsrW-1:0] rnd;
      rnd = CsrW'({$urandom, $urandom});
      case (setting)
         0: begin   // datasheet-like calibration
            write_reg(CSR_AC_S, {16'd408, 16'hFFC8, 16'hC68C});
            write_reg(CSR_AC_U, {16'd32741, 16'd32757, 16'd23153});
            write_reg(CSR_B_PAIR, CsrW'({16'd6190, 16'd4}));
            write_reg(CSR_M_PAIR, CsrW'({16'h8001, 16'd2868}));
         end
         1: begin   // all ones: -1 in signed words, top value in unsigned ones
            write_reg(CSR_AC_S, '1);
            write_reg(CSR_AC_U, '1);
            write_reg(CSR_B_PAIR, '1);
            write_reg(CSR_M_PAIR, '1);
         end
         2: begin   // most negative and top positive words
            write_reg(CSR_AC_S, {16'h8000, 16'h7FFF, 16'h8000});
            write_reg(CSR_AC_U, {16'hFFFF, 16'h8000, 16'h0000});
            write_reg(CSR_B_PAIR, CsrW'({16'h7FFF, 16'h8000}));
            write_reg(CSR_M_PAIR, CsrW'({16'h7FFF, 16'h8000}));
         end
         default: begin
            write_reg(CSR_AC_S, rnd);
            write_reg(CSR_AC_U, CsrW'({$urandom, $urandom}));
            write_reg(CSR_B_PAIR, CsrW'($urandom));
            write_reg(CSR_M_PAIR, CsrW'($urandom));
         end
      endcase
      write_reg(CSR_OSS, CsrW'($urandom_range(3)));
      write_reg(3'd7, CsrW'({$urandom, $urandom}));   // unmapped index, ignored
   endtask

   function automatic sample_t rand_sample();
      sample_t s;
      s.kind = 1'($urandom_range(1));
      case ($urandom_range(3))
         0: s.raw = 24'($urandom);
         1: s.raw = {8'(s.kind ? $urandom_range(255) : $urandom), 16'($urandom)};
         2: s.raw = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
         default: s.raw = 24'(24'h500000 + $urandom_range(24'h3FFFF));
      endcase
      return s;
   endfunction

   initial begin
      oss_q = '0; ac_s_q = '0; ac_u_q = '0; b_pair_q = '0; m_pair_q = '0; b5_q = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pressure before any temperature, with all calibration zero: b4 is zero
      pending_samples.push_back('{KIND_PRESS, 24'h5D23C0});
      // zero temperature divisor with all-zero calibration
      pending_samples.push_back('{KIND_TEMP, 24'h006C0A});
      drain();

      load_cal(0);
      write_reg(CSR_OSS, CsrW'(2'd0));
      pending_samples.push_back('{KIND_PRESS, 24'h5D23C0});
      pending_samples.push_back('{KIND_TEMP, 24'h006C0A});
      pending_samples.push_back('{KIND_TEMP, 24'hFFFFFF});
      pending_samples.push_back('{KIND_TEMP, 24'h000000});
      pending_samples.push_back('{KIND_PRESS, 24'h000000});
      pending_samples.push_back('{KIND_PRESS, 24'hFFFFFF});
      drain();
      write_reg(CSR_OSS, CsrW'(2'd3));
      pending_samples.push_back('{KIND_PRESS, 24'hFFFFFF});
      pending_samples.push_back('{KIND_PRESS, 24'h5D23C0});
      drain();

      // zero temperature divisor with nonzero mc and zero md: x1 = -md
      write_reg(CSR_AC_U, {16'd1000, 16'd32768, 16'd0});
      write_reg(CSR_M_PAIR, CsrW'({16'h8000, 16'd0}));
      pending_samples.push_back('{KIND_TEMP, 24'h000000});
      pending_samples.push_back('{KIND_PRESS, 24'h123456});
      drain();

      for (int unsigned ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin send_idle_pct = 27; recv_idle_pct = 86; end
            1: begin send_idle_pct = 86; recv_idle_pct = 27; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int unsigned blk = 0; blk < 5; blk++) begin
            load_cal(blk == 0 ? ph + 1 : (blk == 1 ? 0 : 3));
            if (ph == 2 && blk == 0) hold_left = 600;   // long receiver hold-off
            for (int n = 0; n < 110; n++) begin
               // mostly temperature then pressure pairs so b5 is fresh
               if ($urandom_range(3) != 0) begin
                  sample_t t;
                  t = rand_sample();
                  t.kind = KIND_TEMP;
                  pending_samples.push_back(t);
                  t = rand_sample();
                  t.kind = KIND_PRESS;
                  pending_samples.push_back(t);
                  n++;
               end else begin
                  pending_samples.push_back(rand_sample());
               end
            end
            drain();
         end
      end

      if (!failed && expected_readings.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
